// ===== rtl/arc_frame_replacer_defines.svh =====
// ----------------------------------------------------------------------------
// arc_frame_replacer_defines
// Assertion macros for the adaptive frame replacer. Empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ARC_FRAME_REPLACER_DEFINES_SVH
`define ARC_FRAME_REPLACER_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define AFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("afr assertion failed");
// Check that a condition implies a consequence in the same cycle.
`define AFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("afr implication failed");
`else
`define AFR_ASSERT(lbl, prop)
`define AFR_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== rtl/afr_pkg.sv =====
// ----------------------------------------------------------------------------
// afr_pkg
// Types and constants of the adaptive frame replacer.
// ----------------------------------------------------------------------------
package afr_pkg;

  localparam int FRAMES_DEF     = 64;
  localparam int PAGE_BITS_DEF  = 31;
  localparam int STAMP_BITS_DEF = 32;

  localparam int CAP_W    = 7;
  localparam int FIDX_W   = 6;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int VICTIM_W = 6;
  localparam int ECNT_W   = 7;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  // Register select bit of paddr: word 0 is the capacity register.
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ACCESS    = 2'd0,
    ACT_SET_EVICT = 2'd1,
    ACT_REMOVE    = 2'd2,
    ACT_EVICT     = 2'd3
  } afr_action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_NOT_RESIDENT = 2'd1,
    ST_PINNED       = 2'd2,
    ST_NO_VICTIM    = 2'd3
  } afr_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FSCAN,
    S_FRD,
    S_FTOG,
    S_HITWR,
    S_GSCAN,
    S_GEND,
    S_DIV,
    S_ADAPT,
    S_FWR,
    S_FINISH
  } afr_state_e;

endpackage

// ===== rtl/afr_div.sv =====
// ----------------------------------------------------------------------------
// afr_div
// Restoring divider, one quotient bit per cycle, for the target step.
// ----------------------------------------------------------------------------
module afr_div #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quotient_o
);

  localparam int CNTW = $clog2(W + 1);

  logic            busy_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  logic [W-1:0]    rem_q;
  logic [W-1:0]    quo_q;
  logic [W-1:0]    dsr_q;
  logic [W:0]      shifted;
  logic            ge;

  assign shifted = {rem_q, quo_q[W-1]};
  assign ge      = shifted >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(W);
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dsr_q  <= divisor_i;
      end else if (busy_q) begin
        // shift in one dividend bit, subtract where it fits
        rem_q <= ge ? W'(shifted - {1'b0, dsr_q}) : shifted[W-1:0];
        quo_q <= {quo_q[W-2:0], ge};
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/arc_frame_replacer.sv =====
// ----------------------------------------------------------------------------
// arc_frame_replacer
// Adaptive replacement policy over buffer frames with recent, frequent and
// ghost sets kept in two synchronous memories.
// ----------------------------------------------------------------------------
// One item is in work at a time; a finished result waits in the output
// register while the next item is already taken. Set evictable, every error
// case and an access to a resident frame run no scan; an access miss and a
// remove scan the 2*FRAMES ghost slots; an evict scans the frames, then the
// ghost slots. A ghost hit also runs the step division when its own ghost
// count is below the other (CW, the ghost count width, is 8 at the default
// size). Scans are linear, one read port delivering one entry a cycle. Age
// order comes from access stamps: the oldest entry has the greatest
// (counter - stamp) modulo 2^STAMP_BITS. Capacity is to be written through
// the APB port only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "arc_frame_replacer_defines.svh"

module arc_frame_replacer
  import afr_pkg::*;
#(
  parameter int FRAMES     = FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ACTION_W-1:0]  action_i,
  input  logic [FIDX_W-1:0]    frame_index_i,
  input  logic [PAGE_BITS-1:0] page_number_i,
  input  logic                 evictable_flag_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [VICTIM_W-1:0]  victim_frame_o,
  output logic [ECNT_W-1:0]    evictable_count_o
);

  localparam int GHOSTS = 2 * FRAMES;
  localparam int FW     = $clog2(FRAMES);
  localparam int GW     = $clog2(GHOSTS);
  localparam int NW     = GW + 1;
  localparam int CW     = $clog2(GHOSTS + 1);
  localparam int XW     = ((CW > CAP_W) ? CW : CAP_W) + 3;
  localparam int EW     = PAGE_BITS + STAMP_BITS;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  afr_state_e state_q, state_d;

  logic [CAP_W-1:0]      cap_q;
  afr_action_e           act_q;
  logic [FW-1:0]         fidx_q;
  logic                  known_q;
  logic [PAGE_BITS-1:0]  page_q;
  logic                  flag_q;

  // per-frame and per-ghost flags, cleared by reset
  logic [FRAMES-1:0]     fres_q, ffreq_q, fcan_q;
  logic [GHOSTS-1:0]     gval_q, gfreq_q;

  logic [CAP_W-1:0]      target_q;
  logic [CW-1:0]         rc_q, fc_q, rgc_q, fgc_q, cec_q;
  logic [STAMP_BITS-1:0] stamp_q;

  afr_status_e           status_q;
  logic [FW-1:0]         vic_q;
  logic                  freq_first_q;

  // scan pipeline: address counter, then one entry of read data a cycle
  logic [NW-1:0]         cnt_q;
  logic                  pv_q;
  logic [GW-1:0]         pidx_q;

  // oldest trackers: recent side, frequent side, either side
  logic                  t0_v_q, t1_v_q, ta_v_q;
  logic [STAMP_BITS-1:0] t0_age_q, t1_age_q, ta_age_q;
  logic [GW-1:0]         t0_idx_q, t1_idx_q, ta_idx_q;
  logic                  match_v_q, inv_v_q;
  logic [GW-1:0]         match_idx_q, inv_idx_q;

  logic                  put_mode_q;
  logic [PAGE_BITS-1:0]  put_page_q;
  logic                  put_freq_q;
  logic                  hit_freq_q;
  logic [GW-1:0]         hit_idx_q;
  logic [CW-1:0]         step_q;

  logic                  out_valid_q;
  afr_status_e           out_status_q;
  logic [VICTIM_W-1:0]   out_victim_q;
  logic [ECNT_W-1:0]     out_ecnt_q;

  // memories
  logic [EW-1:0]         fmem [FRAMES];
  logic [EW-1:0]         gmem [GHOSTS];
  logic [EW-1:0]         f_rdata_q, g_rdata_q;
  logic [FW-1:0]         f_raddr;
  logic [GW-1:0]         g_raddr;
  logic                  f_we, g_we;
  logic [FW-1:0]         f_waddr;
  logic [GW-1:0]         g_waddr;
  logic [EW-1:0]         f_wdata, g_wdata;

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  logic in_accept, out_load, cfg_write;

  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_load   = (state_q == S_FINISH) && (!out_valid_q || !out_stall_i);
  assign cfg_write  = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(cap_q) : '0;

  // --------------------------------------------------------------------------
  // Scan datapath
  // --------------------------------------------------------------------------
  logic [FW-1:0]         scan_fi;
  logic [STAMP_BITS-1:0] s_age;
  logic                  s_elig, s_side, s_last, scan_done;
  logic                  upd0, upd1, upda;
  logic [PAGE_BITS-1:0]  s_page;
  logic [NW-1:0]         scan_end;

  assign scan_fi  = pidx_q[FW-1:0];
  assign scan_end = (state_q == S_FSCAN) ? NW'(FRAMES) : NW'(GHOSTS);
  assign s_last   = (cnt_q == scan_end);
  assign scan_done = s_last && !pv_q;
  assign s_page   = put_mode_q ? put_page_q : page_q;

  always_comb begin
    if (state_q == S_FSCAN) begin
      s_age  = stamp_q - f_rdata_q[STAMP_BITS-1:0];
      s_elig = fres_q[scan_fi] && fcan_q[scan_fi];
      s_side = ffreq_q[scan_fi];
    end else begin
      s_age  = stamp_q - g_rdata_q[STAMP_BITS-1:0];
      s_elig = gval_q[pidx_q];
      s_side = gfreq_q[pidx_q];
    end
  end

  // strict compare keeps the first entry found on equal age
  assign upd0 = pv_q && s_elig && !s_side && (!t0_v_q || (s_age > t0_age_q));
  assign upd1 = pv_q && s_elig && s_side && (!t1_v_q || (s_age > t1_age_q));
  assign upda = pv_q && s_elig && (!ta_v_q || (s_age > ta_age_q));

  // evict victim: preferred side first, then the other
  logic          pick_v;
  logic [GW-1:0] pick_idx;

  assign pick_v   = t0_v_q || t1_v_q;
  assign pick_idx = freq_first_q ? (t1_v_q ? t1_idx_q : t0_idx_q)
                                 : (t0_v_q ? t0_idx_q : t1_idx_q);

  // ghost slot for a put: same page, else a free slot, else the oldest
  logic [GW-1:0] put_slot;
  assign put_slot = match_v_q ? match_idx_q : (inv_v_q ? inv_idx_q : ta_idx_q);

  // --------------------------------------------------------------------------
  // Decode helpers
  // --------------------------------------------------------------------------
  logic          cur_res, cur_can, hit_gfreq, need_div;
  logic [XW-1:0] rc_rgc, all_cnt, up_sum;

  assign cur_res   = fres_q[fidx_q];
  assign cur_can   = fcan_q[fidx_q];
  assign hit_gfreq = gfreq_q[match_idx_q];
  assign need_div  = hit_gfreq ? (fgc_q < rgc_q) : (rgc_q < fgc_q);
  assign rc_rgc    = XW'(rc_q) + XW'(rgc_q);
  assign all_cnt   = rc_rgc + XW'(fc_q) + XW'(fgc_q);
  assign up_sum    = XW'(target_q) + XW'(step_q);

  logic          div_start, div_done;
  logic [CW-1:0] div_quo;

  assign div_start = (state_q == S_GEND) && !put_mode_q && match_v_q && need_div;

  afr_div #(.W(CW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (hit_gfreq ? rgc_q : fgc_q),
    .divisor_i  (hit_gfreq ? fgc_q : rgc_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) state_d = S_DECODE;
      end
      S_DECODE: begin
        state_d = S_FINISH;
        case (act_q)
          ACT_ACCESS: begin
            if (known_q && cur_res) state_d = S_HITWR;
            else if (known_q) state_d = S_GSCAN;
          end
          ACT_REMOVE: begin
            if (known_q && cur_res && cur_can) state_d = S_FTOG;
          end
          ACT_EVICT: begin
            if (cec_q != '0) state_d = S_FSCAN;
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_FSCAN: begin
        if (scan_done) state_d = pick_v ? S_FRD : S_FINISH;
      end
      S_FRD:   state_d = S_FTOG;
      S_FTOG:  state_d = S_GSCAN;
      S_HITWR: state_d = S_FINISH;
      S_GSCAN: begin
        if (scan_done) state_d = S_GEND;
      end
      S_GEND: begin
        if (put_mode_q) state_d = S_FINISH;
        else if (!match_v_q) state_d = S_FWR;
        else if (need_div) state_d = S_DIV;
        else state_d = S_ADAPT;
      end
      S_DIV: begin
        if (div_done) state_d = S_ADAPT;
      end
      S_ADAPT: state_d = S_FWR;
      S_FWR:   state_d = S_FINISH;
      S_FINISH: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Memory ports
  // --------------------------------------------------------------------------
  always_comb begin
    case (state_q)
      S_FSCAN: f_raddr = cnt_q[FW-1:0];
      S_FRD:   f_raddr = vic_q;
      default: f_raddr = fidx_q;
    endcase
    g_raddr = cnt_q[GW-1:0];

    f_we    = (state_q == S_HITWR) || (state_q == S_FWR);
    f_waddr = fidx_q;
    f_wdata = (state_q == S_HITWR) ? {f_rdata_q[EW-1:STAMP_BITS], stamp_q}
                                   : {page_q, stamp_q};
    g_we    = (state_q == S_GEND) && put_mode_q;
    g_waddr = put_slot;
    g_wdata = {put_page_q, stamp_q};
  end

  always_ff @(posedge clk_i) begin
    if (f_we) fmem[f_waddr] <= f_wdata;
    f_rdata_q <= fmem[f_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (g_we) gmem[g_waddr] <= g_wdata;
    g_rdata_q <= gmem[g_raddr];
  end

  // --------------------------------------------------------------------------
  // Datapath and bookkeeping
  // --------------------------------------------------------------------------
  logic dec_f, dec_r;
  assign dec_f = gval_q[put_slot] && gfreq_q[put_slot];
  assign dec_r = gval_q[put_slot] && !gfreq_q[put_slot];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= CAP_RESET;
      act_q        <= ACT_ACCESS;
      fidx_q       <= '0;
      known_q      <= 1'b0;
      page_q       <= '0;
      flag_q       <= 1'b0;
      fres_q       <= '0;
      ffreq_q      <= '0;
      fcan_q       <= '0;
      gval_q       <= '0;
      gfreq_q      <= '0;
      target_q     <= '0;
      rc_q         <= '0;
      fc_q         <= '0;
      rgc_q        <= '0;
      fgc_q        <= '0;
      cec_q        <= '0;
      stamp_q      <= '0;
      status_q     <= ST_OK;
      vic_q        <= '0;
      freq_first_q <= 1'b0;
      cnt_q        <= '0;
      pv_q         <= 1'b0;
      pidx_q       <= '0;
      t0_v_q       <= 1'b0;
      t1_v_q       <= 1'b0;
      ta_v_q       <= 1'b0;
      t0_age_q     <= '0;
      t1_age_q     <= '0;
      ta_age_q     <= '0;
      t0_idx_q     <= '0;
      t1_idx_q     <= '0;
      ta_idx_q     <= '0;
      match_v_q    <= 1'b0;
      inv_v_q      <= 1'b0;
      match_idx_q  <= '0;
      inv_idx_q    <= '0;
      put_mode_q   <= 1'b0;
      put_page_q   <= '0;
      put_freq_q   <= 1'b0;
      hit_freq_q   <= 1'b0;
      hit_idx_q    <= '0;
      step_q       <= '0;
    end else begin
      if (cfg_write) cap_q <= pwdata[CAP_W-1:0];

      // advance the scan pipeline and the oldest trackers
      if ((state_q == S_FSCAN) || (state_q == S_GSCAN)) begin
        pv_q <= !s_last;
        if (!s_last) begin
          cnt_q  <= cnt_q + NW'(1);
          pidx_q <= cnt_q[GW-1:0];
        end
        if (upd0) begin
          t0_v_q <= 1'b1; t0_age_q <= s_age; t0_idx_q <= pidx_q;
        end
        if (upd1) begin
          t1_v_q <= 1'b1; t1_age_q <= s_age; t1_idx_q <= pidx_q;
        end
        if (upda) begin
          ta_v_q <= 1'b1; ta_age_q <= s_age; ta_idx_q <= pidx_q;
        end
        if ((state_q == S_GSCAN) && pv_q) begin
          if (gval_q[pidx_q] && !match_v_q &&
              (g_rdata_q[EW-1:STAMP_BITS] == s_page)) begin
            match_v_q   <= 1'b1;
            match_idx_q <= pidx_q;
          end
          if (!gval_q[pidx_q] && !inv_v_q) begin
            inv_v_q   <= 1'b1;
            inv_idx_q <= pidx_q;
          end
        end
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            act_q   <= afr_action_e'(action_i);
            fidx_q  <= FW'(frame_index_i);
            known_q <= (32'(frame_index_i) < FRAMES);
            page_q  <= page_number_i;
            flag_q  <= evictable_flag_i;
          end
        end

        S_DECODE: begin
          status_q   <= ST_OK;
          put_mode_q <= 1'b0;
          // clear the scan before any scan starts
          cnt_q     <= '0;
          pv_q      <= 1'b0;
          t0_v_q    <= 1'b0;
          t1_v_q    <= 1'b0;
          ta_v_q    <= 1'b0;
          match_v_q <= 1'b0;
          inv_v_q   <= 1'b0;
          case (act_q)
            ACT_ACCESS: begin
              if (!known_q) status_q <= ST_NOT_RESIDENT;
            end
            ACT_SET_EVICT: begin
              if (!known_q || !cur_res) begin
                status_q <= ST_NOT_RESIDENT;
              end else if (cur_can != flag_q) begin
                cec_q          <= flag_q ? cec_q + CW'(1) : cec_q - CW'(1);
                fcan_q[fidx_q] <= flag_q;
              end
            end
            ACT_REMOVE: begin
              if (!known_q || !cur_res) status_q <= ST_NOT_RESIDENT;
              else if (!cur_can) status_q <= ST_PINNED;
              else vic_q <= fidx_q;
            end
            ACT_EVICT: begin
              if (cec_q == '0) status_q <= ST_NO_VICTIM;
              freq_first_q <= ((XW'(rc_q) < XW'(target_q)) && (rc_q != '0)) ||
                              (fc_q == '0);
            end
            default: status_q <= ST_OK;
          endcase
        end

        S_FSCAN: begin
          if (scan_done) begin
            if (pick_v) vic_q <= pick_idx[FW-1:0];
            else status_q <= ST_NO_VICTIM;
          end
        end

        S_FTOG: begin
          // drop the frame from its resident set and queue it as a ghost
          if (fcan_q[vic_q]) cec_q <= cec_q - CW'(1);
          if (ffreq_q[vic_q]) fc_q <= fc_q - CW'(1);
          else rc_q <= rc_q - CW'(1);
          fres_q[vic_q]  <= 1'b0;
          fcan_q[vic_q]  <= 1'b0;
          ffreq_q[vic_q] <= 1'b0;
          put_page_q <= f_rdata_q[EW-1:STAMP_BITS];
          put_freq_q <= ffreq_q[vic_q];
          put_mode_q <= 1'b1;
          cnt_q      <= '0;
          pv_q       <= 1'b0;
          t0_v_q     <= 1'b0;
          t1_v_q     <= 1'b0;
          ta_v_q     <= 1'b0;
          match_v_q  <= 1'b0;
          inv_v_q    <= 1'b0;
        end

        S_HITWR: begin
          stamp_q <= stamp_q + STAMP_BITS'(1);
          if (!ffreq_q[fidx_q]) begin
            ffreq_q[fidx_q] <= 1'b1;
            rc_q <= rc_q - CW'(1);
            fc_q <= fc_q + CW'(1);
          end
        end

        S_GEND: begin
          if (put_mode_q) begin
            stamp_q           <= stamp_q + STAMP_BITS'(1);
            gval_q[put_slot]  <= 1'b1;
            gfreq_q[put_slot] <= put_freq_q;
            fgc_q <= fgc_q - CW'(dec_f) + CW'(put_freq_q);
            rgc_q <= rgc_q - CW'(dec_r) + CW'(!put_freq_q);
          end else if (match_v_q) begin
            hit_idx_q  <= match_idx_q;
            hit_freq_q <= hit_gfreq;
            step_q     <= CW'(1);
          end else begin
            // miss: make room in the ghost lists, then enter recent
            if (rc_rgc == XW'(cap_q)) begin
              if (t0_v_q) begin
                gval_q[t0_idx_q] <= 1'b0;
                rgc_q <= rgc_q - CW'(1);
              end
            end else if (all_cnt == XW'({cap_q, 1'b0})) begin
              if (t1_v_q) begin
                gval_q[t1_idx_q] <= 1'b0;
                fgc_q <= fgc_q - CW'(1);
              end
            end
            ffreq_q[fidx_q] <= 1'b0;
            rc_q <= rc_q + CW'(1);
          end
        end

        S_DIV: begin
          if (div_done) step_q <= div_quo;
        end

        S_ADAPT: begin
          if (!hit_freq_q) begin
            target_q <= (up_sum > XW'(cap_q)) ? cap_q : CAP_W'(up_sum);
            rgc_q    <= rgc_q - CW'(1);
          end else begin
            target_q <= (XW'(target_q) > XW'(step_q)) ?
                        CAP_W'(XW'(target_q) - XW'(step_q)) : '0;
            fgc_q    <= fgc_q - CW'(1);
          end
          gval_q[hit_idx_q] <= 1'b0;
          ffreq_q[fidx_q]   <= 1'b1;
          fc_q <= fc_q + CW'(1);
        end

        S_FWR: begin
          stamp_q        <= stamp_q + STAMP_BITS'(1);
          fres_q[fidx_q] <= 1'b1;
          fcan_q[fidx_q] <= 1'b0;
        end

        default: begin
          status_q <= status_q;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_victim_q <= '0;
      out_ecnt_q   <= '0;
    end else begin
      if (out_load) begin
        out_valid_q  <= 1'b1;
        out_status_q <= status_q;
        out_victim_q <= ((act_q == ACT_EVICT) && (status_q == ST_OK)) ?
                        VICTIM_W'(vic_q) : '0;
        out_ecnt_q   <= ECNT_W'(cec_q);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign victim_frame_o    = out_victim_q;
  assign evictable_count_o = out_ecnt_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic evict_none_out;
  assign evict_none_out = out_load && (act_q == ACT_EVICT) && (status_q == ST_NO_VICTIM);

  `AFR_ASSERT(a_cec_bound, (XW'(cec_q) <= (XW'(rc_q) + XW'(fc_q))))
  `AFR_ASSERT(a_ghost_bound, ((XW'(rgc_q) + XW'(fgc_q)) <= XW'(GHOSTS)))
  `AFR_ASSERT_IMP(a_no_victim, evict_none_out, (cec_q == '0))

endmodule
